// ===== rtl/hcb_pkg.sv =====
`timescale 1ns / 1ps
package hcb_pkg;
  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_HSTART = 5'd2;
  localparam logic [4:0] S_RD0    = 5'd3;
  localparam logic [4:0] S_RD1    = 5'd4;
  localparam logic [4:0] S_RD2    = 5'd5;
  localparam logic [4:0] S_SD0    = 5'd6;
  localparam logic [4:0] S_SD1    = 5'd7;
  localparam logic [4:0] S_SD2    = 5'd8;
  localparam logic [4:0] S_SD3    = 5'd9;
  localparam logic [4:0] S_PAIR   = 5'd10;
  localparam logic [4:0] S_TK0    = 5'd11;
  localparam logic [4:0] S_TK1    = 5'd12;
  localparam logic [4:0] S_TK2    = 5'd13;
  localparam logic [4:0] S_MK0    = 5'd14;
  localparam logic [4:0] S_MK1    = 5'd15;
  localparam logic [4:0] S_MK2    = 5'd16;
  localparam logic [4:0] S_PU0    = 5'd17;
  localparam logic [4:0] S_PU1    = 5'd18;
  localparam logic [4:0] S_PU2    = 5'd19;
  localparam logic [4:0] S_RT0    = 5'd20;
  localparam logic [4:0] S_RT1    = 5'd21;
  localparam logic [4:0] S_WK0    = 5'd22;
  localparam logic [4:0] S_WK1    = 5'd23;
  localparam logic [4:0] S_WK2    = 5'd24;
  localparam logic [4:0] S_WK3    = 5'd25;
  localparam logic [4:0] S_DONE   = 5'd26;
endpackage

// ===== rtl/hcb_ram.sv =====
`timescale 1ns / 1ps
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/huffman_code_builder.sv =====
`timescale 1ns / 1ps
// Loading accepts one item per cycle; busy refuses start from the final item to the last code.
// Each sift-down reads the node and its weight, then per heap level reads both children and
// moves the lighter child up; a merge takes two sifts, adds the two weights and sifts the new
// node up. The walk pops one stack entry per node and pushes each internal node's children.
// Results leave one per leaf, each strobed for one cycle; the receiver cannot stall.
// Synchronous reset returns the block to loading with an empty set.
module huffman_code_builder
  import hcb_pkg::*;
#(
  parameter int NUM_SYMBOLS = 32,
  parameter int WEIGHT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  symbol,
  input  logic [23:0] frequency,
  input  logic        final_entry,
  output logic        strobe,
  output logic [7:0]  code_symbol,
  output logic [30:0] code_word,
  output logic [4:0]  code_length,
  output logic        last_code,
  output logic        overflow
);
  localparam int NN = 2 * NUM_SYMBOLS;
  localparam int NB = $clog2(NN);
  localparam int CB = $clog2(NUM_SYMBOLS + 1);
  localparam int SB = $clog2(NUM_SYMBOLS);
  localparam int WB = WEIGHT_BITS + SB + 1;
  localparam int KW = NB + 32 + 6;
  localparam logic [WB-1:0] WMASK = WB'((64'd1 << WEIGHT_BITS) - 64'd1);

  logic [4:0] state;
  logic [CB-1:0] hcount, leaves;
  logic [SB:0] nmade;
  logic dropped;

  logic wt_we; logic [NB-1:0] wt_wa, wt_ra; logic [WB-1:0] wt_wd, wt_rd;
  logic hp_we; logic [SB-1:0] hp_wa, hp_ra; logic [NB-1:0] hp_wd, hp_rd;
  logic ls_we; logic [SB-1:0] ls_wa, ls_ra; logic [7:0] ls_wd, ls_rd;
  logic ch_we; logic [SB-1:0] ch_wa, ch_ra; logic [2*NB-1:0] ch_wd, ch_rd;
  logic st_we; logic [SB-1:0] st_wa, st_ra; logic [KW-1:0] st_wd, st_rd;

  hcb_ram #(.WIDTH(WB), .DEPTH(NN)) u_wt (.clk, .we(wt_we), .waddr(wt_wa),
    .wdata(wt_wd), .raddr(wt_ra), .rdata(wt_rd));
  hcb_ram #(.WIDTH(NB), .DEPTH(NUM_SYMBOLS)) u_hp (.clk, .we(hp_we), .waddr(hp_wa),
    .wdata(hp_wd), .raddr(hp_ra), .rdata(hp_rd));
  hcb_ram #(.WIDTH(8), .DEPTH(NUM_SYMBOLS)) u_ls (.clk, .we(ls_we), .waddr(ls_wa),
    .wdata(ls_wd), .raddr(ls_ra), .rdata(ls_rd));
  hcb_ram #(.WIDTH(2*NB), .DEPTH(NUM_SYMBOLS)) u_ch (.clk, .we(ch_we), .waddr(ch_wa),
    .wdata(ch_wd), .raddr(ch_ra), .rdata(ch_rd));
  hcb_ram #(.WIDTH(KW), .DEPTH(NUM_SYMBOLS)) u_st (.clk, .we(st_we), .waddr(st_wa),
    .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

  logic [CB-1:0] i, idx, best, hi, ph, sel_idx, sp, emitted;
  logic [CB:0] lc, rc;
  logic [NB-1:0] cur_node, ln, rn, bnode, sel_node, na, nb, nnode, nnew, pn;
  logic [NB-1:0] e_node, st_node;
  logic [WB-1:0] cur_w, bw, wa, wnew, wsum;
  logic [31:0] e_code;
  logic [5:0] e_len;
  logic taking, second, right_better, leaf, emit;

  assign busy = (state != S_LOAD);
  assign lc = {idx, 1'b1};
  assign rc = {idx, 1'b0} + (CB+1)'(2);
  assign ph = (hi - CB'(1)) >> 1;
  assign nnew = NB'(NUM_SYMBOLS) + NB'(nmade);
  assign wsum = wa + wt_rd;
  assign right_better = (rc < (CB+1)'(hcount)) && (wt_rd < bw);
  assign sel_idx = right_better ? rc[CB-1:0] : best;
  assign sel_node = right_better ? rn : bnode;
  assign st_node = st_rd[KW-1 -: NB];
  assign leaf = (e_node < NB'(NUM_SYMBOLS));
  assign emit = (state == S_WK2) && leaf && (emitted < CB'(NUM_SYMBOLS));

  always_comb begin
    wt_we = 1'b0; wt_wa = '0; wt_wd = '0; wt_ra = '0;
    hp_we = 1'b0; hp_wa = '0; hp_wd = '0; hp_ra = '0;
    ls_we = 1'b0; ls_wa = '0; ls_wd = '0; ls_ra = '0;
    ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_ra = '0;
    st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
    case (state)
      S_LOAD: begin
        if (start && hcount < CB'(NUM_SYMBOLS)) begin
          ls_we = 1'b1; ls_wa = hcount[SB-1:0]; ls_wd = symbol;
          wt_we = 1'b1; wt_wa = NB'(hcount);
          wt_wd = WB'(frequency) & WMASK;
        end
      end
      S_INIT: begin
        hp_we = 1'b1; hp_wa = i[SB-1:0]; hp_wd = NB'(i);
      end
      S_RD0: hp_ra = idx[SB-1:0];
      S_RD1: wt_ra = hp_rd;
      S_SD0: hp_ra = lc[SB-1:0];
      S_SD1: begin
        wt_ra = hp_rd; hp_ra = rc[SB-1:0];
      end
      S_SD2: wt_ra = hp_rd;
      S_SD3: begin
        hp_we = 1'b1; hp_wa = idx[SB-1:0]; hp_wd = sel_node;
      end
      S_TK0: hp_ra = '0;
      S_TK1: hp_ra = SB'(hcount - CB'(1));
      S_TK2: wt_ra = hp_rd;
      S_MK0: wt_ra = na;
      S_MK1: wt_ra = nb;
      S_MK2: begin
        wt_we = 1'b1; wt_wa = nnew; wt_wd = wsum;
        ch_we = 1'b1; ch_wa = nmade[SB-1:0]; ch_wd = {na, nb};
      end
      S_PU0: begin
        if (hi == '0) begin
          hp_we = 1'b1; hp_wa = '0; hp_wd = nnode;
        end else begin
          hp_ra = ph[SB-1:0];
        end
      end
      S_PU1: wt_ra = hp_rd;
      S_PU2: begin
        hp_we = 1'b1; hp_wa = hi[SB-1:0];
        hp_wd = (wnew < wt_rd) ? pn : nnode;
      end
      S_RT0: hp_ra = '0;
      S_RT1: begin
        st_we = 1'b1; st_wa = '0; st_wd = {hp_rd, 32'd0, 6'd0};
      end
      S_WK0: st_ra = SB'(sp - CB'(1));
      S_WK1: begin
        ls_ra = st_node[SB-1:0];
        ch_ra = SB'(st_node - NB'(NUM_SYMBOLS));
      end
      S_WK2: begin
        ch_ra = SB'(e_node - NB'(NUM_SYMBOLS));
        if (!leaf && sp < CB'(NUM_SYMBOLS)) begin
          st_we = 1'b1; st_wa = sp[SB-1:0];
          st_wd = {ch_rd[NB-1:0], e_code[30:0], 1'b1, e_len + 6'd1};
        end
      end
      S_WK3: begin
        if (sp < CB'(NUM_SYMBOLS)) begin
          st_we = 1'b1; st_wa = sp[SB-1:0];
          st_wd = {ch_rd[2*NB-1:NB], e_code[30:0], 1'b0, e_len + 6'd1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; hcount <= '0; nmade <= '0; dropped <= 1'b0;
      strobe <= 1'b0; code_symbol <= '0; code_word <= '0; code_length <= '0;
      last_code <= 1'b0; overflow <= 1'b0;
    end else begin
      strobe <= emit;
      if (emit) begin
        code_symbol <= ls_rd; code_word <= e_code[30:0];
        code_length <= e_len[4:0]; overflow <= dropped;
        last_code <= (sp == '0);
        emitted <= emitted + CB'(1);
      end
      case (state)
        S_LOAD: begin
          if (start) begin
            if (hcount < CB'(NUM_SYMBOLS)) hcount <= hcount + CB'(1);
            else dropped <= 1'b1;
            if (final_entry) begin
              leaves <= (hcount < CB'(NUM_SYMBOLS)) ? hcount + CB'(1) : hcount;
              i <= '0; state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (i + CB'(1) >= leaves) begin
            nmade <= '0;
            if (leaves >= CB'(2)) begin
              i <= (leaves - CB'(2)) >> 1; taking <= 1'b0; state <= S_HSTART;
            end else state <= S_RT0;
          end else i <= i + CB'(1);
        end
        S_HSTART: begin idx <= i; state <= S_RD0; end
        S_RD0: state <= S_RD1;
        S_RD1: begin cur_node <= hp_rd; state <= S_RD2; end
        S_RD2: begin cur_w <= wt_rd; state <= S_SD0; end
        S_SD0: state <= S_SD1;
        S_SD1: begin ln <= hp_rd; state <= S_SD2; end
        S_SD2: begin
          rn <= hp_rd;
          if (lc < (CB+1)'(hcount) && wt_rd < cur_w) begin
            best <= lc[CB-1:0]; bnode <= ln; bw <= wt_rd;
          end else begin
            best <= idx; bnode <= cur_node; bw <= cur_w;
          end
          state <= S_SD3;
        end
        S_SD3: begin
          if (sel_idx != idx) begin
            idx <= sel_idx; state <= S_SD0;
          end else if (!taking) begin
            if (i == '0) state <= S_PAIR;
            else begin i <= i - CB'(1); state <= S_HSTART; end
          end else if (!second) begin
            second <= 1'b1; state <= S_TK0;
          end else state <= S_MK0;
        end
        S_PAIR: begin
          if (hcount > CB'(1) && nmade < (SB+1)'(NUM_SYMBOLS - 1)) begin
            taking <= 1'b1; second <= 1'b0; state <= S_TK0;
          end else state <= S_RT0;
        end
        S_TK0: state <= S_TK1;
        S_TK1: begin
          if (!second) na <= hp_rd;
          else nb <= hp_rd;
          hcount <= hcount - CB'(1);
          state <= S_TK2;
        end
        S_TK2: begin cur_node <= hp_rd; idx <= '0; state <= S_RD2; end
        S_MK0: state <= S_MK1;
        S_MK1: begin wa <= wt_rd; state <= S_MK2; end
        S_MK2: begin
          wnew <= wsum; nnode <= nnew; nmade <= nmade + (SB+1)'(1);
          hi <= hcount; hcount <= hcount + CB'(1);
          state <= S_PU0;
        end
        S_PU0: begin
          if (hi == '0) state <= S_PAIR;
          else state <= S_PU1;
        end
        S_PU1: begin pn <= hp_rd; state <= S_PU2; end
        S_PU2: begin
          if (wnew < wt_rd) begin
            hi <= ph; state <= S_PU0;
          end else state <= S_PAIR;
        end
        S_RT0: state <= S_RT1;
        S_RT1: begin sp <= CB'(1); emitted <= '0; state <= S_WK0; end
        S_WK0: begin
          if (sp == '0) state <= S_DONE;
          else begin sp <= sp - CB'(1); state <= S_WK1; end
        end
        S_WK1: begin
          e_node <= st_node; e_code <= st_rd[37:6]; e_len <= st_rd[5:0];
          state <= S_WK2;
        end
        S_WK2: begin
          if (leaf) state <= S_WK0;
          else begin
            if (sp < CB'(NUM_SYMBOLS)) sp <= sp + CB'(1);
            state <= S_WK3;
          end
        end
        S_WK3: begin
          if (sp < CB'(NUM_SYMBOLS)) sp <= sp + CB'(1);
          state <= S_WK0;
        end
        S_DONE: begin
          hcount <= '0; nmade <= '0; dropped <= 1'b0; state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== bench/huffman_code_builder_test.sv =====
`timescale 1ns / 1ps
module huffman_code_builder_test;

  typedef struct {
    logic [7:0]  sym;
    logic [30:0] word;
    logic [4:0]  len;
    logic        last;
    logic        ovf;
  } code_t;

  class code_table_model;
    logic [31:0] weight[63];
    logic [7:0] leaf_sym[32];
    int unsigned lchild[31];
    int unsigned rchild[31];
    int unsigned slots[32];
    int unsigned held;
    bit dropped;
    code_t expected_codes[$];
    int errors;
    int checked;
    int longest;

    function new();
      foreach (weight[i]) weight[i] = '0;
      foreach (leaf_sym[i]) leaf_sym[i] = '0;
      foreach (lchild[i]) begin
        lchild[i] = 0;
        rchild[i] = 0;
      end
      foreach (slots[i]) slots[i] = 0;
      held = 0;
      dropped = 0;
      errors = 0;
      checked = 0;
      longest = 0;
    endfunction

    function logic [31:0] slot_w(int unsigned s);
      return weight[slots[s % 32] % 63];
    endfunction

    function void sift_down(int unsigned idx);
      int unsigned best, l, r, t;
      forever begin
        best = idx;
        l = 2 * idx + 1;
        r = 2 * idx + 2;
        if (l < held && slot_w(l) < slot_w(best)) best = l;
        if (r < held && slot_w(r) < slot_w(best)) best = r;
        if (best == idx) return;
        t = slots[best];
        slots[best] = slots[idx];
        slots[idx] = t;
        idx = best;
      end
    endfunction

    function int unsigned take_min();
      int unsigned n;
      n = slots[0];
      held--;
      slots[0] = slots[held % 32];
      sift_down(0);
      return n;
    endfunction

    function void put_node(int unsigned n);
      int unsigned i;
      logic [31:0] w;
      i = held;
      w = weight[n % 63];
      held++;
      while (i > 0 && w < slot_w((i - 1) / 2)) begin
        slots[i] = slots[(i - 1) / 2];
        i = (i - 1) / 2;
      end
      slots[i % 32] = n;
    endfunction

    function void build_codes();
      int unsigned leaves, made, a, b, sp, emitted, k;
      int unsigned st_node[32];
      logic [63:0] st_code[32];
      int unsigned st_len[32];
      int unsigned e_node, e_len;
      logic [63:0] e_code;
      code_t c;
      leaves = held;
      emitted = 0;
      for (int i = 0; i < leaves; i++) slots[i] = i;
      if (leaves >= 2) begin
        for (int i = (leaves - 2) / 2; i >= 0; i--) sift_down(i);
      end
      made = 0;
      while (held > 1 && made < 31) begin
        a = take_min();
        b = take_min();
        lchild[made] = a;
        rchild[made] = b;
        weight[(32 + made) % 63] = weight[a % 63] + weight[b % 63];
        put_node(32 + made);
        made++;
      end
      st_node[0] = slots[0];
      st_code[0] = '0;
      st_len[0] = 0;
      sp = 1;
      while (sp > 0) begin
        sp--;
        e_node = st_node[sp];
        e_code = st_code[sp];
        e_len = st_len[sp];
        if (e_node < 32) begin
          if (emitted < 32) begin
            c.sym = leaf_sym[e_node];
            c.word = e_code[30:0];
            c.len = e_len[4:0];
            c.last = 1'b0;
            c.ovf = dropped;
            expected_codes.push_back(c);
            if (e_len > longest) longest = e_len;
            emitted++;
          end
        end else begin
          k = (e_node - 32) % 31;
          if (sp < 32) begin
            st_node[sp] = rchild[k];
            st_code[sp] = (e_code << 1) | 64'd1;
            st_len[sp] = e_len + 1;
            sp++;
          end
          if (sp < 32) begin
            st_node[sp] = lchild[k];
            st_code[sp] = e_code << 1;
            st_len[sp] = e_len + 1;
            sp++;
          end
        end
      end
      if (emitted > 0) expected_codes[expected_codes.size() - 1].last = 1'b1;
      held = 0;
      dropped = 0;
    endfunction

    function void note_entry(logic [7:0] sym, logic [23:0] freq, logic fin);
      if (held < 32) begin
        leaf_sym[held] = sym;
        weight[held] = {8'd0, freq};
        held++;
      end else begin
        dropped = 1;
      end
      if (fin) build_codes();
    endfunction

    function void check_code(code_t got);
      code_t want;
      checked++;
      if (expected_codes.size() == 0) begin
        errors++;
        $display("%0t: unexpected code sym=%0h word=%0h len=%0d", $time, got.sym,
                 got.word, got.len);
        return;
      end
      want = expected_codes.pop_front();
      if (got.sym !== want.sym) begin
        errors++;
        $display("%0t: code_symbol expected %0h actual %0h", $time, want.sym, got.sym);
      end
      if (got.word !== want.word) begin
        errors++;
        $display("%0t: code_word expected %0h actual %0h", $time, want.word, got.word);
      end
      if (got.len !== want.len) begin
        errors++;
        $display("%0t: code_length expected %0d actual %0d", $time, want.len, got.len);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last_code expected %0b actual %0b", $time, want.last, got.last);
      end
      if (got.ovf !== want.ovf) begin
        errors++;
        $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, got.ovf);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, final_entry, strobe, last_code, overflow;
  logic [7:0] symbol, code_symbol;
  logic [23:0] frequency;
  logic [30:0] code_word;
  logic [4:0] code_length;

  code_table_model codes;
  int idle_pct;
  int items_sent;
  int sets_sent;
  int overflow_sets;

  huffman_code_builder u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .symbol(symbol), .frequency(frequency), .final_entry(final_entry),
    .strobe(strobe), .code_symbol(code_symbol), .code_word(code_word),
    .code_length(code_length), .last_code(last_code), .overflow(overflow)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Timeout waiting for the block.");
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    code_t got;
    if (!rst && strobe) begin
      got.sym = code_symbol;
      got.word = code_word;
      got.len = code_length;
      got.last = last_code;
      got.ovf = overflow;
      codes.check_code(got);
    end
  end

  task send_entry(input logic [7:0] sym, input logic [23:0] freq, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    symbol = sym;
    frequency = freq;
    final_entry = fin;
    while (busy) @(negedge clk);
    codes.note_entry(sym, freq, fin);
    items_sent++;
    @(posedge clk);
  endtask

  task release_line();
    @(negedge clk);
    start = 0;
  endtask

  task drain();
    release_line();
    while (codes.expected_codes.size() > 0) @(posedge clk);
  endtask

  task send_set(input int n, input int style);
    logic [23:0] f, fa, fb;
    fa = 1;
    fb = 1;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: f = 24'($urandom_range(15));
        1: f = 24'($urandom);
        default: begin
          f = fa;
          fa = fb;
          fb = f + fb;
        end
      endcase
      send_entry(8'($urandom_range(255)), f, i == n - 1);
    end
    if (n > 32) overflow_sets++;
    sets_sent++;
  endtask

  initial begin
    int n, pick;
    codes = new();
    items_sent = 0;
    sets_sent = 0;
    overflow_sets = 0;
    idle_pct = 21;
    start = 0;
    symbol = 0;
    frequency = 0;
    final_entry = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_entry(8'hff, 24'hffffff, 1);
    send_entry(8'h00, 24'h000000, 0);
    send_entry(8'hff, 24'hffffff, 1);
    for (int i = 0; i < 4; i++) send_entry(8'h10 + i, 24'd7, i == 3);
    for (int i = 0; i < 3; i++) send_entry(8'h40 + i, 24'd0, i == 2);
    send_entry(8'haa, 24'h800000, 0);
    send_entry(8'h55, 24'h7fffff, 0);
    send_entry(8'h01, 24'h000001, 1);
    drain();

    send_set(32, 2);
    send_set(34, 1);
    while (items_sent < 200) begin
      if (items_sent > 150) idle_pct = 0;
      else if (items_sent > 90) idle_pct = 69;
      pick = $urandom_range(99);
      if (pick < 75) n = $urandom_range(2, 8);
      else if (pick < 88) n = $urandom_range(9, 32);
      else if (pick < 94) n = $urandom_range(33, 36);
      else n = 1;
      send_set(n, $urandom_range(99) < 10 ? 2 : $urandom_range(1));
      if ($urandom_range(99) < 15) drain();
    end

    drain();
    repeat (300) @(posedge clk);
    $display("Sent %0d entries in %0d sets (%0d over capacity); checked %0d codes.",
             items_sent, sets_sent, overflow_sets, codes.checked);
    $display("Longest code length seen: %0d.", codes.longest);
    if (codes.errors == 0 && codes.expected_codes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
